>>> rtl/dqu_pkg.sv
// ----------------------------------------------------------------------------
// dqu_pkg
// shared types and codes for the double-ended queue unit
// ----------------------------------------------------------------------------
`default_nettype none

package dqu_pkg;

	localparam int unsigned DATA_W = 32;

	typedef logic [2:0] cmd_t;
	typedef logic [1:0] status_t;
	typedef logic signed [DATA_W-1:0] data_t;

	// command codes
	localparam cmd_t CMD_PUSH_BACK  = 3'd0;
	localparam cmd_t CMD_PUSH_FRONT = 3'd1;
	localparam cmd_t CMD_POP_FRONT  = 3'd2;
	localparam cmd_t CMD_POP_BACK   = 3'd3;
	localparam cmd_t CMD_QUERY      = 3'd4;

	// status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	typedef enum logic {
		DQU_IDLE,
		DQU_FETCH
	} dqu_state_t;

endpackage

`default_nettype wire

>>> rtl/dqu_ring_ram.sv
// ----------------------------------------------------------------------------
// dqu_ring_ram
// ring store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_ring_ram
	import dqu_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [IW-1:0] wr_addr,
	input  wire data_t         wr_data,
	input  wire logic          rd_en,
	input  wire logic [IW-1:0] rd_addr,
	output data_t              rd_data
);

	data_t mem [DEPTH];
	data_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded deque of signed 32-bit values held in a ring store
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     in_valid / in_stall     command, value
//  output    out_valid / out_stall   status, removed_value, front_value,
//                                    back_value, element_count, is_empty
//
//  pushes, queries, refused requests and pops that leave at most one
//  element load the output register directly; a pop that leaves two or
//  more first fetches the new end value over the store's single read port
//  front and back values are cached in registers, so the store is only
//  read for a pop that exposes a new end
//  reset clears index, count and control; the store needs no clearing
//  a result stalled in the output register holds off new requests, as does
//  a pop waiting on its store read
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit
	import dqu_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// request channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire cmd_t                       command,
	input  wire data_t                      value,
	// result channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output status_t                         status,
	output data_t                           removed_value,
	output data_t                           front_value,
	output data_t                           back_value,
	output logic [$clog2(DEPTH+1)-1:0]      element_count,
	output logic                            is_empty
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);
	localparam logic [CW-1:0] TWO_CNT  = CW'(2);

	// control state
	dqu_state_t     state_q, state_d;
	logic [IW-1:0]  front_idx_q, front_idx_d;
	logic [IW-1:0]  back_idx_q, back_idx_d;
	logic [CW-1:0]  count_q, count_d;
	logic           out_valid_q;

	// cached end values (zero when empty)
	data_t          front_val_q, front_val_d;
	data_t          back_val_q, back_val_d;

	// pop waiting on a store read
	logic           pend_front_s1, pend_front_d;
	data_t          removed_s1, removed_d;

	// output register
	status_t        status_q;
	data_t          removed_q, front_out_q, back_out_q;
	logic [CW-1:0]  count_out_q;

	// store access
	logic           wr_en, rd_en;
	logic [IW-1:0]  wr_addr, rd_addr;
	data_t          rd_data;

	// result load
	logic           load;
	status_t        res_status;
	data_t          res_removed, res_front, res_back;

	// ring index helpers
	logic           empty_now, full_now;
	logic [IW-1:0]  front_inc, front_dec, back_inc, back_dec;
	logic           out_free, accept;

	assign empty_now = (count_q == '0);
	assign full_now  = (count_q == FULL_CNT);
	assign front_inc = (front_idx_q == LAST_IDX) ? '0 : front_idx_q + IW'(1);
	assign front_dec = (front_idx_q == '0) ? LAST_IDX : front_idx_q - IW'(1);
	assign back_inc  = (back_idx_q == LAST_IDX) ? '0 : back_idx_q + IW'(1);
	assign back_dec  = (back_idx_q == '0) ? LAST_IDX : back_idx_q - IW'(1);

	// output register can take a new result this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != DQU_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	dqu_ring_ram #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// next state and request decode
	always_comb begin
		state_d      = state_q;
		front_idx_d  = front_idx_q;
		back_idx_d   = back_idx_q;
		count_d      = count_q;
		front_val_d  = front_val_q;
		back_val_d   = back_val_q;
		pend_front_d = pend_front_s1;
		removed_d    = removed_s1;
		wr_en        = 1'b0;
		wr_addr      = front_idx_q;
		rd_en        = 1'b0;
		rd_addr      = front_inc;
		load         = 1'b0;
		res_status   = ST_OK;
		res_removed  = '0;
		res_front    = front_val_q;
		res_back     = back_val_q;

		case (state_q)
			DQU_IDLE: begin
				if (accept) begin
					load = 1'b1;
					case (command)
						CMD_PUSH_BACK: begin
							if (full_now) begin
								res_status = ST_FULL;
							end else begin
								wr_en       = 1'b1;
								wr_addr     = empty_now ? front_idx_q : back_inc;
								back_idx_d  = wr_addr;
								count_d     = count_q + ONE_CNT;
								back_val_d  = value;
								if (empty_now) begin
									front_val_d = value;
								end
							end
						end
						CMD_PUSH_FRONT: begin
							if (full_now) begin
								res_status = ST_FULL;
							end else begin
								wr_en       = 1'b1;
								wr_addr     = front_dec;
								front_idx_d = front_dec;
								count_d     = count_q + ONE_CNT;
								front_val_d = value;
								if (empty_now) begin
									back_idx_d = front_dec;
									back_val_d = value;
								end
							end
						end
						CMD_POP_FRONT: begin
							if (empty_now) begin
								res_status = ST_EMPTY;
							end else begin
								res_removed = front_val_q;
								front_idx_d = front_inc;
								count_d     = count_q - ONE_CNT;
								if (count_q == ONE_CNT) begin
									front_val_d = '0;
									back_val_d  = '0;
								end else if (count_q == TWO_CNT) begin
									front_val_d = back_val_q;
								end else begin
									// new front lives only in the store
									rd_en        = 1'b1;
									rd_addr      = front_inc;
									load         = 1'b0;
									pend_front_d = 1'b1;
									removed_d    = front_val_q;
									state_d      = DQU_FETCH;
								end
							end
						end
						CMD_POP_BACK: begin
							if (empty_now) begin
								res_status = ST_EMPTY;
							end else begin
								res_removed = back_val_q;
								back_idx_d  = back_dec;
								count_d     = count_q - ONE_CNT;
								if (count_q == ONE_CNT) begin
									front_val_d = '0;
									back_val_d  = '0;
								end else if (count_q == TWO_CNT) begin
									back_val_d = front_val_q;
								end else begin
									rd_en        = 1'b1;
									rd_addr      = back_dec;
									load         = 1'b0;
									pend_front_d = 1'b0;
									removed_d    = back_val_q;
									state_d      = DQU_FETCH;
								end
							end
						end
						default: begin
							// query and unused codes change nothing
						end
					endcase
					res_front = front_val_d;
					res_back  = back_val_d;
				end
			end
			DQU_FETCH: begin
				// store data is held until the output register frees up
				if (out_free) begin
					load        = 1'b1;
					res_removed = removed_s1;
					if (pend_front_s1) begin
						front_val_d = rd_data;
					end else begin
						back_val_d = rd_data;
					end
					res_front = front_val_d;
					res_back  = back_val_d;
					state_d   = DQU_IDLE;
				end
			end
			default: begin
				state_d = DQU_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DQU_IDLE;
			front_idx_q <= '0;
			back_idx_q  <= '0;
			count_q     <= '0;
			front_val_q <= '0;
			back_val_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			front_idx_q <= front_idx_d;
			back_idx_q  <= back_idx_d;
			count_q     <= count_d;
			front_val_q <= front_val_d;
			back_val_q  <= back_val_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pend_front_s1 <= pend_front_d;
		removed_s1    <= removed_d;
		if (load) begin
			status_q    <= res_status;
			removed_q   <= res_removed;
			front_out_q <= res_front;
			back_out_q  <= res_back;
			count_out_q <= count_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign front_value   = front_out_q;
	assign back_value    = back_out_q;
	assign element_count = count_out_q;
	assign is_empty      = (count_out_q == '0);

endmodule

`default_nettype wire

>>> rtl/dqu_checker.sv
// ----------------------------------------------------------------------------
// dqu_checker
// port-level checks for the double-ended queue unit
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_checker
	import dqu_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire status_t                    status,
	input wire data_t                      removed_value,
	input wire data_t                      front_value,
	input wire data_t                      back_value,
	input wire logic [$clog2(DEPTH+1)-1:0] element_count,
	input wire logic                       is_empty
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(removed_value) && $stable(element_count))
		else $error("stalled result changed");

	// empty deque shows zero ends
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> element_count == '0
			&& front_value == '0 && back_value == '0)
		else $error("empty result with nonzero fields");

	// refused push only when full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> element_count == CW'(DEPTH)
			&& removed_value == '0)
		else $error("full status with room left");

	// refused pop only when empty
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> is_empty && removed_value == '0)
		else $error("empty status with elements stored");

endmodule

bind double_ended_queue_unit dqu_checker #(.DEPTH(DEPTH)) u_dqu_checker (.*);

`default_nettype wire
